// ===== rtl/stag_pkg.sv =====
//----------------------------------------------------------------------------
// stag_pkg
// Shared types and constants for the scanline texel address generator.
//----------------------------------------------------------------------------
package stag_pkg;

  localparam int SCREEN_WIDTH_DEF = 640;

  // Texture selector codes.
  localparam logic [1:0] SEL_BACK  = 2'd0;
  localparam logic [1:0] SEL_ROAD  = 2'd1;
  localparam logic [1:0] SEL_LEFT  = 2'd2;
  localparam logic [1:0] SEL_RIGHT = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_ZOOM_STEP     = 3'd0;
  localparam logic [2:0] REG_BORDER_PX     = 3'd1;
  localparam logic [2:0] REG_VIEW_X        = 3'd2;
  localparam logic [2:0] REG_BACK_DRIFT_X  = 3'd3;
  localparam logic [2:0] REG_BACK_DRIFT_Y  = 3'd4;
  localparam logic [2:0] REG_FRONT_DRIFT_X = 3'd5;
  localparam logic [2:0] REG_FRONT_DRIFT_Y = 3'd6;

  // Load enables, one per pipeline stage.
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
    logic e;
  } stag_adv_t;

  // Span decision, leaving the classifier.
  typedef struct packed {
    logic               off;
    logic               wrap;
    logic [1:0]         sel;
    logic [6:0]         row;
    logic [12:0]        delta;
    logic [9:0]         base;
    logic signed [16:0] shift;
  } stag_cls_t;

  // Products, leaving the multiplier stage.
  typedef struct packed {
    logic               off;
    logic               wrap;
    logic [1:0]         sel;
    logic [6:0]         row;
    logic [28:0]        step;
    logic [25:0]        base;
    logic signed [16:0] shift;
  } stag_prod_t;

  // Finished texel address.
  typedef struct packed {
    logic [6:0] col;
    logic [6:0] row;
    logic [1:0] sel;
  } stag_out_t;

endpackage

// ===== rtl/stag_classify.sv =====
//----------------------------------------------------------------------------
// stag_classify
// Two stages: edge and border arithmetic, then span selection and start.
//----------------------------------------------------------------------------
module stag_classify #(
  parameter int SCREEN_WIDTH = stag_pkg::SCREEN_WIDTH_DEF
) (
  input  logic               clk,
  input  stag_pkg::stag_adv_t adv,
  input  logic [9:0]         pixel_x,
  input  logic [15:0]        edge_a,
  input  logic [15:0]        edge_b,
  input  logic [15:0]        edge_c,
  input  logic [15:0]        edge_d,
  input  logic [15:0]        world_row,
  input  logic [11:0]        border_px,
  input  logic [15:0]        view_x,
  input  logic [15:0]        back_drift_x,
  input  logic [15:0]        back_drift_y,
  input  logic [15:0]        front_drift_x,
  input  logic [15:0]        front_drift_y,
  output stag_pkg::stag_cls_t cls
);
  import stag_pkg::*;

  localparam logic [10:0] ScreenW = 11'(SCREEN_WIDTH);

  logic signed [17:0] pe, ea, eb, ec, ed, bp, span;
  logic signed [17:0] re_a_next, le_b_next, re_c_next, mid_next, le_d_next;

  // Stage A registers.
  logic [9:0]         a_p;
  logic signed [17:0] a_ea, a_eb, a_ec, a_ed;
  logic signed [17:0] a_re_a, a_le_b, a_re_c, a_mid, a_le_d;
  logic               a_lt_a, a_lt_b, a_lt_c, a_lt_d, a_ovl, a_off;
  logic [6:0]         a_wrow;

  // Stage B logic.
  logic signed [17:0] bpe, le_m, re_m, start, start0, dsub;
  logic               wrap;
  logic [1:0]         sel;
  logic [15:0]        dx, dy;
  stag_cls_t          cls_next;

  always_comb begin
    pe   = signed'({8'b0, pixel_x});
    ea   = {{2{edge_a[15]}}, edge_a};
    eb   = {{2{edge_b[15]}}, edge_b};
    ec   = {{2{edge_c[15]}}, edge_c};
    ed   = {{2{edge_d[15]}}, edge_d};
    bp   = signed'({6'b0, border_px});
    span = ec - eb;
    re_a_next = ea - bp;
    le_b_next = eb + bp;
    re_c_next = ec - bp;
    mid_next  = eb + (span >>> 1);
    le_d_next = ed + bp;
  end

  always_ff @(posedge clk) begin
    if (adv.a) begin
      a_p    <= pixel_x;
      a_ea   <= ea;
      a_eb   <= eb;
      a_ec   <= ec;
      a_ed   <= ed;
      a_re_a <= re_a_next;
      a_le_b <= le_b_next;
      a_re_c <= re_c_next;
      a_mid  <= mid_next;
      a_le_d <= le_d_next;
      a_lt_a <= pe < ea;
      a_lt_b <= pe < eb;
      a_lt_c <= pe < ec;
      a_lt_d <= pe < ed;
      a_ovl  <= le_b_next > re_c_next;
      a_off  <= {1'b0, pixel_x} >= ScreenW;
      a_wrow <= world_row[6:0];
    end
  end

  always_comb begin
    bpe  = signed'({8'b0, a_p});
    // Borders that would overlap both meet at the middle of the span.
    le_m = a_ovl ? a_mid : a_le_b;
    re_m = a_ovl ? a_mid : a_re_c;
    sel   = SEL_BACK;
    wrap  = 1'b1;
    start = '0;
    if (a_lt_a) begin
      if (bpe < a_re_a) begin
        sel   = SEL_BACK;
        wrap  = 1'b1;
        start = '0;
      end else begin
        sel   = SEL_RIGHT;
        wrap  = 1'b0;
        start = a_re_a;
      end
    end else if (a_lt_b) begin
      sel   = SEL_ROAD;
      wrap  = 1'b1;
      start = a_ea;
    end else if (a_lt_c) begin
      if (bpe < le_m) begin
        sel   = SEL_LEFT;
        wrap  = 1'b0;
        start = a_eb;
      end else if (bpe < re_m) begin
        sel   = SEL_BACK;
        wrap  = 1'b1;
        start = le_m;
      end else begin
        sel   = SEL_RIGHT;
        wrap  = 1'b0;
        start = re_m;
      end
    end else if (a_lt_d) begin
      sel   = SEL_ROAD;
      wrap  = 1'b1;
      start = a_ec;
    end else if (bpe < a_le_d) begin
      sel   = SEL_LEFT;
      wrap  = 1'b0;
      start = a_ed;
    end else begin
      sel   = SEL_BACK;
      wrap  = 1'b1;
      start = a_le_d;
    end

    // A wrapped span never starts left of the screen, and its start never
    // passes the pixel, so the clamped start fits in a pixel column.
    start0 = start[17] ? '0 : start;
    dsub   = bpe - (wrap ? start0 : start);

    dx = (sel == SEL_ROAD) ? front_drift_x : back_drift_x;
    case (sel)
      SEL_ROAD: dy = front_drift_y;
      SEL_BACK: dy = back_drift_y;
      default:  dy = '0;
    endcase

    cls_next.off   = a_off;
    cls_next.wrap  = wrap;
    cls_next.sel   = sel;
    cls_next.row   = dy[6:0] - a_wrow;
    cls_next.delta = dsub[12:0];
    cls_next.base  = start0[9:0];
    cls_next.shift = signed'({view_x[15], view_x}) + signed'({dx[15], dx});
  end

  always_ff @(posedge clk) begin
    if (adv.b) begin
      cls <= cls_next;
    end
  end

endmodule

// ===== rtl/stag_mult.sv =====
//----------------------------------------------------------------------------
// stag_mult
// Multiplier stage: scales the in-span distance and the span start by zoom.
//----------------------------------------------------------------------------
module stag_mult (
  input  logic                clk,
  input  stag_pkg::stag_adv_t  adv,
  input  logic [15:0]         zoom_step,
  input  stag_pkg::stag_cls_t  cls,
  output stag_pkg::stag_prod_t prod
);
  import stag_pkg::*;

  always_ff @(posedge clk) begin
    if (adv.c) begin
      prod.off   <= cls.off;
      prod.wrap  <= cls.wrap;
      prod.sel   <= cls.sel;
      prod.row   <= cls.row;
      prod.shift <= cls.shift;
      prod.step  <= 29'(cls.delta) * 29'(zoom_step);
      prod.base  <= 26'(cls.base) * 26'(zoom_step);
    end
  end

endmodule

// ===== rtl/stag_compose.sv =====
//----------------------------------------------------------------------------
// stag_compose
// Two stages: span origin with truncation toward zero and border
// saturation, then the final column sum into the output register.
//----------------------------------------------------------------------------
module stag_compose (
  input  logic                clk,
  input  stag_pkg::stag_adv_t  adv,
  input  stag_pkg::stag_prod_t prod,
  output stag_pkg::stag_out_t  res
);
  import stag_pkg::*;

  logic signed [27:0] sum, adj;

  // Stage D registers.
  logic       d_off, d_wrap;
  logic [1:0] d_sel;
  logic [6:0] d_row, d_org, d_step;
  logic [3:0] d_bcol;

  always_comb begin
    sum = signed'({2'b0, prod.base}) + signed'({{3{prod.shift[16]}}, prod.shift, 8'b0});
    // Adding 255 to a negative sum makes the shift round toward zero.
    adj = sum + (sum[27] ? 28'sd255 : 28'sd0);
  end

  always_ff @(posedge clk) begin
    if (adv.d) begin
      d_off  <= prod.off;
      d_wrap <= prod.wrap;
      d_sel  <= prod.sel;
      d_row  <= prod.row;
      d_org  <= adj[14:8];
      d_step <= prod.step[14:8];
      d_bcol <= (|prod.step[28:12]) ? 4'hf : prod.step[11:8];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.e) begin
      if (d_off) begin
        res <= '0;
      end else begin
        res.sel <= d_sel;
        res.row <= d_row;
        res.col <= d_wrap ? (d_org + d_step) : {3'b0, d_bcol};
      end
    end
  end

endmodule

// ===== rtl/scanline_texel_address_generator.sv =====
//----------------------------------------------------------------------------
// scanline_texel_address_generator
// Maps a screen pixel to a texture selector and a texel row and column.
//----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per transfer (column, four road edges and the
//   world row); m_axis returns one texel address per pixel, in order.
//   The cfg channel writes the seven registers by index; it is always ready.
//   It must be written only while no pixel is in flight; the block itself
//   does not enforce this.
// Pipeline: edge arithmetic, span selection, the zoom multipliers, the span
//   origin and the final column sum; every stage has its own valid bit.
// Throughput: one pixel per cycle while m_axis_tready is high.
// Stall: when m_axis_tready is low the result stays in the output register
//   and stages upstream keep loading until they hold valid data, so input
//   is still accepted while bubbles remain.
// Reset: all valid bits clear and the registers return to zoom 1.0,
//   a border of 16 pixels and zero offsets.
//----------------------------------------------------------------------------
module scanline_texel_address_generator #(
  parameter int SCREEN_WIDTH = stag_pkg::SCREEN_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_x[9:0], edge_a[25:10], edge_b[41:26], edge_c[57:42],
  // edge_d[73:58], world_row[89:74], zero fill[95:90]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // texture_select[1:0], texel_row[8:2], texel_col[15:9]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import stag_pkg::*;

  logic [15:0] zoom_step;
  logic [11:0] border_px;
  logic [15:0] view_x, back_drift_x, back_drift_y, front_drift_x, front_drift_y;

  logic [4:0]  valid;
  stag_adv_t   adv;
  stag_cls_t   cls;
  stag_prod_t  prod;
  stag_out_t   res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom_step     <= 16'd256;
      border_px     <= 12'd16;
      view_x        <= '0;
      back_drift_x  <= '0;
      back_drift_y  <= '0;
      front_drift_x <= '0;
      front_drift_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ZOOM_STEP:     zoom_step     <= cfg_data;
        REG_BORDER_PX:     border_px     <= cfg_data[11:0];
        REG_VIEW_X:        view_x        <= cfg_data;
        REG_BACK_DRIFT_X:  back_drift_x  <= cfg_data;
        REG_BACK_DRIFT_Y:  back_drift_y  <= cfg_data;
        REG_FRONT_DRIFT_X: front_drift_x <= cfg_data;
        REG_FRONT_DRIFT_Y: front_drift_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or the stage after it loads.
  always_comb begin
    adv.e = !valid[4] || m_axis_tready;
    adv.d = !valid[3] || adv.e;
    adv.c = !valid[2] || adv.d;
    adv.b = !valid[1] || adv.c;
    adv.a = !valid[0] || adv.b;
  end

  assign s_axis_tready = adv.a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv.a) valid[0] <= s_axis_tvalid;
      if (adv.b) valid[1] <= valid[0];
      if (adv.c) valid[2] <= valid[1];
      if (adv.d) valid[3] <= valid[2];
      if (adv.e) valid[4] <= valid[3];
    end
  end

  stag_classify #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_classify (
    .clk           (clk),
    .adv           (adv),
    .pixel_x       (s_axis_tdata[9:0]),
    .edge_a        (s_axis_tdata[25:10]),
    .edge_b        (s_axis_tdata[41:26]),
    .edge_c        (s_axis_tdata[57:42]),
    .edge_d        (s_axis_tdata[73:58]),
    .world_row     (s_axis_tdata[89:74]),
    .border_px     (border_px),
    .view_x        (view_x),
    .back_drift_x  (back_drift_x),
    .back_drift_y  (back_drift_y),
    .front_drift_x (front_drift_x),
    .front_drift_y (front_drift_y),
    .cls           (cls)
  );

  stag_mult u_mult (
    .clk       (clk),
    .adv       (adv),
    .zoom_step (zoom_step),
    .cls       (cls),
    .prod      (prod)
  );

  stag_compose u_compose (
    .clk  (clk),
    .adv  (adv),
    .prod (prod),
    .res  (res)
  );

  assign m_axis_tvalid = valid[4];
  assign m_axis_tdata  = res;

endmodule

// ===== rtl/stag_checker.sv =====
//----------------------------------------------------------------------------
// stag_checker
// Port-level checks for the scanline texel address generator.
//----------------------------------------------------------------------------
module stag_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // A held result does not change until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  // A free output means every stage moves, so input is taken too.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output is free");

  // Border textures are sixteen texels wide.
  a_border_col: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[15:13] == 3'b000)
    else $error("border column beyond fifteen");

endmodule

bind scanline_texel_address_generator stag_checker u_stag_checker (.*);
